// ===== hdl/idea_block_cipher_assert.svh =====
// Assertion macros used by the checker of the cipher block.
`ifndef IDEA_BLOCK_CIPHER_ASSERT_SVH
`define IDEA_BLOCK_CIPHER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define IDEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds from the cycle after the antecedent.
`define IDEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package idea_pkg;

  localparam int Rounds   = 8;
  localparam int KeyW     = 128;
  localparam int RotBits  = 25;
  localparam int InvSteps = 16;
  localparam int CfgIdxW  = 2;
  localparam logic [17:0] MulMod = 18'h10001;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KsIdle,
    KsLoad,
    KsIter
  } ks_state_e;

  typedef struct packed {
    logic        enc;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] x3;
  } blk_t;

  typedef struct packed {
    blk_t        w;
    logic [15:0] t;
  } mid_t;

  typedef logic [5:0][15:0] rkeys_t;
  typedef logic [3:0][15:0] okeys_t;

  // Multiplication modulo 65537 with the value 0 standing for 65536.
  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] x;
    logic [16:0] y;
    logic [33:0] p;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] r;
    x  = (a == 16'h0) ? 17'h10000 : {1'b0, a};
    y  = (b == 16'h0) ? 17'h10000 : {1'b0, b};
    p  = {17'b0, x} * {17'b0, y};
    lo = {2'b0, p[15:0]};
    hi = {1'b0, p[32:16]};
    if (lo < hi) begin
      r = lo + MulMod - hi;
    end else begin
      r = lo - hi;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/idea_block_cipher.sv =====
// IDEA cipher engine, 64-bit blocks under a 128-bit key held in two 64-bit
// registers. Each round is split over three register stages, one per chained
// modular multiplication, and the output transform adds one more; a new block
// can enter every cycle unless the output stalls or a rebuild is running.
// Writing either key register starts a recomputation of the 2*ROUNDS+2 inverse
// subkeys on one shared square-and-multiply unit, one inverse after the other;
// no block is accepted until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module idea_block_cipher #(
  parameter int ROUNDS = idea_pkg::Rounds
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [idea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [63:0]                   block_in_i,
  input  logic                          is_encrypt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [63:0]                   block_out_o
);

  localparam int NK = 6 * ROUNDS + 4;

  logic [NK-1:0][15:0]  enc_keys;
  logic [NK-1:0][15:0]  dec_keys;
  logic                 busy;
  idea_pkg::blk_t       data [ROUNDS+1];
  logic                 vld  [ROUNDS+1];
  logic                 rdy  [ROUNDS+1];

  idea_keysched #(
    .ROUNDS(ROUNDS)
  ) u_keysched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .enc_keys_o (enc_keys),
    .dec_keys_o (dec_keys)
  );

  assign data[0].enc = is_encrypt_i;
  assign data[0].x0  = block_in_i[63:48];
  assign data[0].x1  = block_in_i[47:32];
  assign data[0].x2  = block_in_i[31:16];
  assign data[0].x3  = block_in_i[15:0];
  assign vld[0]      = in_valid_i && !busy;
  assign in_ready_o  = rdy[0] && !busy;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    idea_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[r]),
      .in_ready_o  (rdy[r]),
      .in_data_i   (data[r]),
      .enc_keys_i  (enc_keys[6*r +: 6]),
      .dec_keys_i  (dec_keys[6*r +: 6]),
      .out_valid_o (vld[r+1]),
      .out_ready_i (rdy[r+1]),
      .out_data_o  (data[r+1])
    );
  end

  idea_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[ROUNDS]),
    .in_ready_o  (rdy[ROUNDS]),
    .in_data_i   (data[ROUNDS]),
    .enc_keys_i  (enc_keys[6*ROUNDS +: 4]),
    .dec_keys_i  (dec_keys[6*ROUNDS +: 4]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .block_out_o (block_out_o)
  );

endmodule

`default_nettype wire

// ===== hdl/idea_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module idea_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idea_pkg::blk_t      in_data_i,
  input  idea_pkg::okeys_t    enc_keys_i,
  input  idea_pkg::okeys_t    dec_keys_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         block_out_o
);

  logic              valid_q;
  logic [63:0]       data_q;
  logic [63:0]       data_d;
  idea_pkg::okeys_t  k;

  assign in_ready_o = !valid_q || out_ready_i;
  assign k          = in_data_i.enc ? enc_keys_i : dec_keys_i;

  always_comb begin
    data_d[63:48] = idea_pkg::mul_mod(in_data_i.x0, k[0]);
    data_d[47:32] = in_data_i.x2 + k[1];
    data_d[31:16] = in_data_i.x1 + k[2];
    data_d[15:0]  = idea_pkg::mul_mod(in_data_i.x3, k[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign block_out_o = data_q;

endmodule

`default_nettype wire

// ===== hdl/idea_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module idea_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  idea_pkg::blk_t    in_data_i,
  input  idea_pkg::rkeys_t  enc_keys_i,
  input  idea_pkg::rkeys_t  dec_keys_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output idea_pkg::blk_t    out_data_o
);

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  idea_pkg::blk_t    s1_q, s1_d;
  idea_pkg::mid_t    s2_q, s2_d;
  idea_pkg::blk_t    s3_q, s3_d;
  idea_pkg::rkeys_t  z1, z2, z3;
  logic [15:0]       t1;
  logic [15:0]       t2;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign z1 = in_data_i.enc ? enc_keys_i : dec_keys_i;
  assign z2 = s1_q.enc ? enc_keys_i : dec_keys_i;
  assign z3 = s2_q.w.enc ? enc_keys_i : dec_keys_i;

  always_comb begin
    s1_d.enc = in_data_i.enc;
    s1_d.x0  = idea_pkg::mul_mod(in_data_i.x0, z1[0]);
    s1_d.x1  = in_data_i.x1 + z1[1];
    s1_d.x2  = in_data_i.x2 + z1[2];
    s1_d.x3  = idea_pkg::mul_mod(in_data_i.x3, z1[3]);
  end

  always_comb begin
    s2_d.w = s1_q;
    s2_d.t = idea_pkg::mul_mod(s1_q.x0 ^ s1_q.x2, z2[4]);
  end

  always_comb begin
    t1      = idea_pkg::mul_mod((s2_q.w.x1 ^ s2_q.w.x3) + s2_q.t, z3[5]);
    t2      = s2_q.t + t1;
    s3_d.enc = s2_q.w.enc;
    s3_d.x0  = s2_q.w.x0 ^ t1;
    s3_d.x1  = s2_q.w.x2 ^ t1;
    s3_d.x2  = s2_q.w.x1 ^ t2;
    s3_d.x3  = s2_q.w.x3 ^ t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

`default_nettype wire

// ===== hdl/idea_keysched.sv =====
`timescale 1ns / 1ps
`default_nettype none

module idea_keysched #(
  parameter int ROUNDS = idea_pkg::Rounds
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [idea_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [63:0]                         cfg_data_i,
  output logic                                busy_o,
  output logic [6*ROUNDS+3:0][15:0]           enc_keys_o,
  output logic [6*ROUNDS+3:0][15:0]           dec_keys_o
);

  localparam int NK    = 6 * ROUNDS + 4;
  localparam int NI    = 2 * ROUNDS + 2;
  localparam int SlotW = $clog2(NI);
  localparam int StepW = $clog2(idea_pkg::InvSteps);

  logic [idea_pkg::KeyW-1:0]   key_q;
  logic [NK-1:0][15:0]         enc;
  logic [NK-1:0][15:0]         dec_d;
  logic [NK-1:0][15:0]         dec_q;
  logic [NI-1:0][15:0]         inv_src;
  logic [15:0]                 inv_q [NI];
  idea_pkg::ks_state_e         state_q, state_d;
  logic [SlotW-1:0]            slot_q;
  logic [StepW-1:0]            step_q;
  logic [15:0]                 acc_q, acc_d;
  logic [15:0]                 base_q, base_d;
  logic                        key_write;
  logic                        last_step;
  logic                        last_slot;

  assign key_write = cfg_we_i &&
                     (cfg_idx_i == idea_pkg::RegKeyHigh || cfg_idx_i == idea_pkg::RegKeyLow);
  assign last_step = step_q == StepW'(idea_pkg::InvSteps - 1);
  assign last_slot = slot_q == SlotW'(NI - 1);

  for (genvar n = 0; n < NK; n++) begin : g_enc
    localparam int Rot = (idea_pkg::RotBits * (n / 8)) % idea_pkg::KeyW;
    localparam int Msb = 2 * idea_pkg::KeyW - 1 - 16 * (n % 8);
    logic [2*idea_pkg::KeyW-1:0] dbl;
    assign dbl    = {key_q, key_q} << Rot;
    assign enc[n] = dbl[Msb -: 16];
  end

  assign inv_src[0] = enc[6*ROUNDS];
  assign inv_src[1] = enc[6*ROUNDS+3];
  assign dec_d[0]   = inv_q[0];
  assign dec_d[1]   = 16'h0 - enc[6*ROUNDS+1];
  assign dec_d[2]   = 16'h0 - enc[6*ROUNDS+2];
  assign dec_d[3]   = inv_q[1];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_dec
    localparam int Src = 6 * (ROUNDS - 1 - r);
    localparam int Dst = 6 * r + 4;
    localparam int Na  = (r == ROUNDS - 1) ? 1 : 2;
    localparam int Nb  = (r == ROUNDS - 1) ? 2 : 1;
    assign inv_src[2+2*r] = enc[Src];
    assign inv_src[3+2*r] = enc[Src+3];
    assign dec_d[Dst]     = enc[Src+4];
    assign dec_d[Dst+1]   = enc[Src+5];
    assign dec_d[Dst+2]   = inv_q[2+2*r];
    assign dec_d[Dst+3]   = 16'h0 - enc[Src+Na];
    assign dec_d[Dst+4]   = 16'h0 - enc[Src+Nb];
    assign dec_d[Dst+5]   = inv_q[3+2*r];
  end

  assign acc_d  = idea_pkg::mul_mod(acc_q, base_q);
  assign base_d = idea_pkg::mul_mod(base_q, base_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idea_pkg::KsIdle: state_d = idea_pkg::KsIdle;
      idea_pkg::KsLoad: state_d = idea_pkg::KsIter;
      idea_pkg::KsIter: begin
        if (last_step) begin
          state_d = last_slot ? idea_pkg::KsIdle : idea_pkg::KsLoad;
        end
      end
      default: state_d = idea_pkg::KsIdle;
    endcase
    if (key_write) begin
      state_d = idea_pkg::KsLoad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idea_pkg::KsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      slot_q <= '0;
      step_q <= '0;
      acc_q  <= '0;
      base_q <= '0;
      dec_q  <= '0;
      for (int i = 0; i < NI; i++) begin
        inv_q[i] <= '0;
      end
    end else begin
      dec_q <= dec_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          idea_pkg::RegKeyHigh: key_q[127:64] <= cfg_data_i;
          idea_pkg::RegKeyLow:  key_q[63:0]   <= cfg_data_i;
          default: ;
        endcase
      end
      if (key_write) begin
        slot_q <= '0;
        step_q <= '0;
      end else begin
        unique case (state_q)
          idea_pkg::KsLoad: begin
            acc_q  <= 16'h1;
            base_q <= inv_src[slot_q];
            step_q <= '0;
          end
          idea_pkg::KsIter: begin
            acc_q  <= acc_d;
            base_q <= base_d;
            step_q <= step_q + StepW'(1);
            if (last_step) begin
              inv_q[slot_q] <= acc_d;
              slot_q        <= slot_q + SlotW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign busy_o     = state_q != idea_pkg::KsIdle;
  assign enc_keys_o = enc;
  assign dec_keys_o = dec_q;

endmodule

`default_nettype wire

// ===== hdl/idea_block_cipher_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "idea_block_cipher_assert.svh"

module idea_block_cipher_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [idea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [63:0]                   block_out_o
);

  logic key_write;
  logic bad_write;

  assign key_write = cfg_we_i &&
                     (cfg_idx_i == idea_pkg::RegKeyHigh || cfg_idx_i == idea_pkg::RegKeyLow);
  assign bad_write = cfg_we_i &&
                     cfg_idx_i != idea_pkg::RegKeyHigh && cfg_idx_i != idea_pkg::RegKeyLow;

  // A stalled result word stays on the port unchanged.
  `IDEA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(block_out_o), "result word changed while stalled")

  // A key write blocks input while the inverse subkeys are rebuilt.
  `IDEA_ASSERT_NEXT(a_key_busy, key_write, !in_ready_o ##1 !in_ready_o, "input accepted during subkey rebuild")

  // A write to an unknown register starts no rebuild.
  `IDEA_ASSERT_NEXT(a_bad_idx, bad_write && in_ready_o && !in_valid_i, in_ready_o, "unknown register write stalled the input")

endmodule

bind idea_block_cipher idea_block_cipher_chk u_chk (.*);

`default_nettype wire
